### rtl/fnq_pkg.sv
`default_nettype none

package fnq_pkg;

  // item kinds as they arrive on the input channel
  typedef enum logic [1:0] {
    OP_LOAD_NORM = 2'd0,
    OP_LOAD_BND  = 2'd1,
    OP_FEATURE   = 2'd2
  } op_e;

  // configuration register indexes
  localparam logic [0:0] CFG_NUM_LEVELS  = 1'd0;
  localparam logic [0:0] CFG_FEATURE_DIM = 1'd1;

  localparam logic [8:0] NUM_LEVELS_RST  = 9'd16;
  localparam logic [6:0] FEATURE_DIM_RST = 7'd39;

  // q15 product scaling
  localparam int unsigned FRAC_BITS = 15;

  // entries in the queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  typedef struct packed {
    op_e         op;
    logic [7:0]  idx;
    logic [31:0] value;
    logic [31:0] scale;
    logic [5:0]  dim_index;
    logic [9:0]  frame_index;
    logic        last;
  } entry_t;

endpackage

`default_nettype wire

### rtl/fnq_fifo.sv
`default_nettype none

module fnq_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire fnq_pkg::entry_t entry_i,
  input  wire logic            pop_i,
  output fnq_pkg::entry_t      head_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int unsigned PtrW = (fnq_pkg::Q_DEPTH > 1) ? $clog2(fnq_pkg::Q_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(fnq_pkg::Q_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(fnq_pkg::Q_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(fnq_pkg::Q_DEPTH);

  fnq_pkg::entry_t q_mem [fnq_pkg::Q_DEPTH];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

### rtl/fnq_front.sv
`default_nettype none

module fnq_front #(
  parameter int unsigned MAX_DIM    = 64,
  parameter int unsigned MAX_LEVELS = 256,
  parameter int unsigned MAX_FRAMES = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic        [1:0]  kind_i,
  input  wire logic        [7:0]  index_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic signed [31:0] scale_i,
  input  wire logic        [6:0]  feature_dim_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output fnq_pkg::entry_t         entry_o
);

  localparam int unsigned DimW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned FrmW = $clog2(MAX_FRAMES);
  localparam logic [8:0]  MaxDim9  = 9'(MAX_DIM);
  localparam logic [8:0]  NumBnd9  = 9'(MAX_LEVELS - 1);
  localparam logic [FrmW-1:0] FrmLast = FrmW'(MAX_FRAMES - 1);

  logic [DimW-1:0] dim_cnt_q, dim_cnt_d;
  logic [FrmW-1:0] frm_cnt_q, frm_cnt_d;
  logic            accept, keep, is_feat, last;
  logic [8:0]      fd_ext, dim_eff;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // clamp the frame length to 1..MAX_DIM
  assign fd_ext  = {2'b00, feature_dim_i};
  assign dim_eff = (fd_ext == '0) ? 9'd1 : ((fd_ext > MaxDim9) ? MaxDim9 : fd_ext);
  assign last    = (9'(dim_cnt_q) + 9'd1) >= dim_eff;

  // drop unused kinds and out-of-range table writes here
  always_comb begin
    keep    = 1'b0;
    is_feat = 1'b0;
    case (kind_i)
      fnq_pkg::OP_LOAD_NORM: keep = ({1'b0, index_i} < MaxDim9);
      fnq_pkg::OP_LOAD_BND:  keep = ({1'b0, index_i} < NumBnd9);
      fnq_pkg::OP_FEATURE: begin
        keep    = 1'b1;
        is_feat = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    entry_o.op          = fnq_pkg::op_e'(kind_i);
    entry_o.idx         = is_feat ? 8'(dim_cnt_q) : index_i;
    entry_o.value       = value_i;
    entry_o.scale       = scale_i;
    entry_o.dim_index   = 6'(dim_cnt_q);
    entry_o.frame_index = 10'(frm_cnt_q);
    entry_o.last        = last;
  end

  assign push_o = accept && keep;

  always_comb begin
    dim_cnt_d = dim_cnt_q;
    frm_cnt_d = frm_cnt_q;
    if (accept && is_feat) begin
      if (last) begin
        dim_cnt_d = '0;
        frm_cnt_d = (frm_cnt_q == FrmLast) ? '0 : frm_cnt_q + 1'b1;
      end else begin
        dim_cnt_d = dim_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_cnt_q <= '0;
      frm_cnt_q <= '0;
    end else begin
      dim_cnt_q <= dim_cnt_d;
      frm_cnt_q <= frm_cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/fnq_back.sv
`default_nettype none

module fnq_back #(
  parameter int unsigned MAX_DIM    = 64,
  parameter int unsigned MAX_LEVELS = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [8:0]      num_levels_i,
  input  wire logic            empty_i,
  input  wire fnq_pkg::entry_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           level_o,
  output logic [5:0]           dim_index_o,
  output logic [9:0]           frame_index_o,
  output logic                 last_in_frame_o
);

  localparam int unsigned DimW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned BndDep  = MAX_LEVELS - 1;
  localparam int unsigned BndW    = (BndDep > 1) ? $clog2(BndDep) : 1;
  localparam logic [8:0]  MaxLvl9 = 9'(MAX_LEVELS);
  localparam int unsigned Frac    = fnq_pkg::FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [31:0] mean_mem  [MAX_DIM];
  logic [31:0] scale_mem [MAX_DIM];
  logic [31:0] bnd_mem   [BndDep];

  logic [2:0]  state_q, state_d;
  logic        out_valid_q, out_valid_d;

  logic [31:0] mean_rd_q, scale_rd_q, bnd_rd_q;
  logic [31:0] feat_q, diff_q, scl_q, x_q;
  logic signed [63:0] prod_q;
  logic [8:0]  lo_q, hi_q, lo_n, hi_n;
  logic [7:0]  mid_q, mid_n, level_q, level_n;
  logic [5:0]  dim_q;
  logic [9:0]  frm_q;
  logic        last_q;

  logic [8:0]  nlv, nb;
  logic [9:0]  mid_sum;
  logic        gt, eq, few, srch_done, bnd_re, out_free, load_out;

  assign out_free = !out_valid_q || out_ready_i;
  assign load_out = (state_q == S_OUT) && out_free;
  assign pop_o    = (state_q == S_IDLE) && !empty_i;

  // boundaries in use is the saturated level count minus one
  assign nlv = (num_levels_i > MaxLvl9) ? MaxLvl9 : num_levels_i;
  assign nb  = nlv - 9'd1;
  assign few = (num_levels_i < 9'd2);

  assign gt = $signed(x_q) > $signed(bnd_rd_q);
  assign eq = (x_q == bnd_rd_q);

  // search window is [lo, hi) with hi exclusive
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (state_q == S_INIT) begin
      lo_n = '0;
      hi_n = nb;
    end else if (gt) begin
      lo_n = {1'b0, mid_q} + 9'd1;
    end else if (!eq) begin
      hi_n = {1'b0, mid_q};
    end
    mid_sum   = {1'b0, lo_n} + {1'b0, hi_n} - 10'd1;
    mid_n     = mid_sum[8:1];
    srch_done = (state_q == S_SRCH) && (eq || (lo_n >= hi_n));
    level_n   = eq ? mid_q : lo_n[7:0];
    bnd_re    = ((state_q == S_INIT) && !few) || ((state_q == S_SRCH) && !srch_done);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (pop_o && (head_i.op == fnq_pkg::OP_FEATURE)) begin
          state_d = S_SUB;
        end
      end
      S_SUB:  state_d = S_MUL;
      S_MUL:  state_d = S_INIT;
      S_INIT: state_d = few ? S_OUT : S_SRCH;
      S_SRCH: begin
        if (srch_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // coefficient and boundary tables
  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.op == fnq_pkg::OP_LOAD_NORM)) begin
      mean_mem[head_i.idx[DimW-1:0]]  <= head_i.value;
      scale_mem[head_i.idx[DimW-1:0]] <= head_i.scale;
    end
    if (pop_o && (head_i.op == fnq_pkg::OP_LOAD_BND)) begin
      bnd_mem[head_i.idx[BndW-1:0]] <= head_i.value;
    end
    if (pop_o && (head_i.op == fnq_pkg::OP_FEATURE)) begin
      mean_rd_q  <= mean_mem[head_i.idx[DimW-1:0]];
      scale_rd_q <= scale_mem[head_i.idx[DimW-1:0]];
    end
    if (bnd_re) begin
      bnd_rd_q <= bnd_mem[mid_n[BndW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      feat_q <= head_i.value;
      dim_q  <= head_i.dim_index;
      frm_q  <= head_i.frame_index;
      last_q <= head_i.last;
    end
    if (state_q == S_SUB) begin
      diff_q <= feat_q - mean_rd_q;
      scl_q  <= scale_rd_q;
    end
    if (state_q == S_MUL) begin
      prod_q <= $signed(diff_q) * $signed(scl_q);
    end
    if (state_q == S_INIT) begin
      x_q     <= prod_q[Frac+31:Frac];
      level_q <= '0;
    end
    if ((state_q == S_INIT) || (state_q == S_SRCH)) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
    end
    if (srch_done) begin
      level_q <= level_n;
    end
    if (load_out) begin
      level_o         <= level_q;
      dim_index_o     <= dim_q;
      frame_index_o   <= frm_q;
      last_in_frame_o <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/feature_normalize_quantize.sv
// Normalizes feature elements against per-dimension mean and q15 inverse
// deviation tables and maps each result to a quantization level by binary
// search over an ascending boundary table. Load transactions (mean/scale or
// boundary) are written to their table as the back end pops them and give no
// result; a feature transaction passes through subtract, multiply and search
// setup, then one search step per boundary memory read, at most 8 steps for
// 255 boundaries and none when fewer than two levels are set. A two-entry
// queue between the input side and the compute side lets new transactions be
// taken while one is in flight, and the output register holds a finished
// result until taken. Tables hold no reset value and need no clearing pass:
// entries must be loaded before use.
`default_nettype none

module feature_normalize_quantize #(
  parameter int unsigned MAX_DIM    = 64,
  parameter int unsigned MAX_LEVELS = 256,
  parameter int unsigned MAX_FRAMES = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic        [0:0]  cfg_addr_i,
  input  wire logic        [8:0]  cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic        [1:0]  kind_i,
  input  wire logic        [7:0]  index_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic signed [31:0] scale_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [7:0]  level_o,
  output logic             [5:0]  dim_index_o,
  output logic             [9:0]  frame_index_o,
  output logic                    last_in_frame_o
);

  logic [8:0] num_levels_q, num_levels_d;
  logic [6:0] feature_dim_q, feature_dim_d;

  fnq_pkg::entry_t push_entry, head_entry;
  logic            push, pop, full, empty;

  always_comb begin
    num_levels_d  = num_levels_q;
    feature_dim_d = feature_dim_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        fnq_pkg::CFG_NUM_LEVELS:  num_levels_d  = cfg_wdata_i;
        fnq_pkg::CFG_FEATURE_DIM: feature_dim_d = cfg_wdata_i[6:0];
        default: num_levels_d = num_levels_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_levels_q  <= fnq_pkg::NUM_LEVELS_RST;
      feature_dim_q <= fnq_pkg::FEATURE_DIM_RST;
    end else begin
      num_levels_q  <= num_levels_d;
      feature_dim_q <= feature_dim_d;
    end
  end

  fnq_front #(
    .MAX_DIM    (MAX_DIM),
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .index_i       (index_i),
    .value_i       (value_i),
    .scale_i       (scale_i),
    .feature_dim_i (feature_dim_q),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  fnq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  fnq_back #(
    .MAX_DIM    (MAX_DIM),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .num_levels_i    (num_levels_q),
    .empty_i         (empty),
    .head_i          (head_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .level_o         (level_o),
    .dim_index_o     (dim_index_o),
    .frame_index_o   (frame_index_o),
    .last_in_frame_o (last_in_frame_o)
  );

endmodule

`default_nettype wire

### rtl/fnq_checker.sv
`default_nettype none

module fnq_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] level_o,
  input wire logic [5:0] dim_index_o,
  input wire logic [9:0] frame_index_o,
  input wire logic       last_in_frame_o
);

  logic       prev_last_q;
  logic [5:0] prev_dim_q;
  logic [9:0] prev_frm_q;
  logic       out_xfer;

  assign out_xfer = out_valid_o && out_ready_i;

  // remember the labels of the last delivered transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_last_q <= 1'b1;
      prev_dim_q  <= '0;
      prev_frm_q  <= '0;
    end else if (out_xfer) begin
      prev_last_q <= last_in_frame_o;
      prev_dim_q  <= dim_index_o;
      prev_frm_q  <= frame_index_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(level_o) &&
    $stable(dim_index_o) && $stable(frame_index_o) && $stable(last_in_frame_o))
    else $error("result changed while stalled");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && prev_last_q |-> dim_index_o == 6'd0)
    else $error("frame does not start at dimension zero");

  a_dim_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !prev_last_q |-> dim_index_o == prev_dim_q + 6'd1)
    else $error("dimension index skipped");

  a_frame_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !prev_last_q |-> frame_index_o == prev_frm_q)
    else $error("frame index changed inside a frame");

endmodule

bind feature_normalize_quantize fnq_checker u_fnq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .level_o         (level_o),
  .dim_index_o     (dim_index_o),
  .frame_index_o   (frame_index_o),
  .last_in_frame_o (last_in_frame_o)
);

`default_nettype wire

### verif/feature_normalize_quantize_checker.sv
`timescale 1ns / 1ps

module feature_normalize_quantize_checker #(
  parameter int unsigned MAX_DIM    = 64,
  parameter int unsigned MAX_LEVELS = 256,
  parameter int unsigned MAX_FRAMES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  index_i,
  input  logic [31:0] value_i,
  input  logic [31:0] scale_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  level_i,
  input  logic [5:0]  dim_index_i,
  input  logic [9:0]  frame_index_i,
  input  logic        last_in_frame_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_checked_o,
  output int          frame_wraps_o
);

  typedef struct packed {
    logic [7:0] level;
    logic [5:0] dim_index;
    logic [9:0] frame_index;
    logic       last;
  } quant_result_t;

  quant_result_t      expected_q[$];
  logic [31:0]        mean_tab  [MAX_DIM];
  logic [31:0]        scale_tab [MAX_DIM];
  logic signed [31:0] bnd_tab   [MAX_LEVELS-1];
  logic [8:0]         levels_cfg;
  logic [6:0]         dim_cfg;
  int                 dim_cnt   = 0;
  int                 frame_cnt = 0;
  int                 n_fail    = 0;
  int                 n_checked = 0;
  int                 n_wraps   = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_fail < 100) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    n_fail++;
  endtask

  // q15 scaling: bits 46..15 of the signed 64-bit product of the wrapped difference
  function automatic logic [31:0] normalize_feature(input logic [31:0] feat,
                                                     input logic [31:0] mu,
                                                     input logic [31:0] inv_sd);
    logic signed [31:0] diff;
    logic signed [31:0] sd;
    logic signed [63:0] prod;
    diff = feat - mu;
    sd   = inv_sd;
    prod = diff * sd;
    return prod[46:15];
  endfunction

  // index of an equal boundary, else the number of boundaries below
  function automatic logic [7:0] quantize_level(input logic signed [31:0] x);
    int lo;
    int hi;
    int mid;
    int nb;
    if (levels_cfg < 2) return '0;
    nb = (levels_cfg > MAX_LEVELS) ? MAX_LEVELS - 1 : levels_cfg - 1;
    lo = 0;
    hi = nb - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (x > bnd_tab[mid]) begin
        lo = mid + 1;
      end else if (x < bnd_tab[mid]) begin
        hi = mid - 1;
      end else begin
        return 8'(mid);
      end
    end
    return 8'(lo);
  endfunction

  always @(posedge clk_i) begin : track
    quant_result_t exp_r;
    int            eff_dim;
    int            slot;
    if (!rst_ni) begin
      dim_cnt    = 0;
      frame_cnt  = 0;
      levels_cfg = fnq_pkg::NUM_LEVELS_RST;
      dim_cfg    = fnq_pkg::FEATURE_DIM_RST;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          fnq_pkg::CFG_NUM_LEVELS:  levels_cfg = cfg_wdata_i;
          fnq_pkg::CFG_FEATURE_DIM: dim_cfg    = cfg_wdata_i[6:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no transaction pending, level", 32'(level_i), '0);
        end else begin
          exp_r = expected_q.pop_front();
          if (level_i !== exp_r.level)
            report_mismatch("level", 32'(level_i), 32'(exp_r.level));
          if (dim_index_i !== exp_r.dim_index)
            report_mismatch("dim_index", 32'(dim_index_i), 32'(exp_r.dim_index));
          if (frame_index_i !== exp_r.frame_index)
            report_mismatch("frame_index", 32'(frame_index_i), 32'(exp_r.frame_index));
          if (last_in_frame_i !== exp_r.last)
            report_mismatch("last_in_frame", 32'(last_in_frame_i), 32'(exp_r.last));
          n_checked++;
        end
      end

      if (in_valid_i && in_ready_i) begin
        case (kind_i)
          fnq_pkg::OP_LOAD_NORM: begin
            if (index_i < MAX_DIM) begin
              mean_tab[index_i]  = value_i;
              scale_tab[index_i] = scale_i;
            end
          end
          fnq_pkg::OP_LOAD_BND: begin
            if (index_i < MAX_LEVELS - 1) bnd_tab[index_i] = value_i;
          end
          fnq_pkg::OP_FEATURE: begin
            eff_dim = (dim_cfg == 0) ? 1 : ((dim_cfg > MAX_DIM) ? MAX_DIM : dim_cfg);
            slot    = (dim_cnt >= MAX_DIM) ? MAX_DIM - 1 : dim_cnt;
            exp_r.level = quantize_level(normalize_feature(value_i, mean_tab[slot],
                                                           scale_tab[slot]));
            exp_r.dim_index   = 6'(dim_cnt);
            exp_r.frame_index = 10'(frame_cnt);
            // a dimension lowered mid-frame closes the frame at once
            exp_r.last        = (dim_cnt + 1 >= eff_dim);
            expected_q.push_back(exp_r);
            if (exp_r.last) begin
              dim_cnt   = 0;
              frame_cnt = (frame_cnt + 1) % MAX_FRAMES;
              if (frame_cnt == 0) n_wraps++;
            end else begin
              dim_cnt++;
            end
          end
          default: ;
        endcase
      end
    end
    fail_count_o      <= n_fail;
    pending_o         <= expected_q.size();
    results_checked_o <= n_checked;
    frame_wraps_o     <= n_wraps;
  end

endmodule

### verif/feature_normalize_quantize_tb.sv
`timescale 1ns / 1ps

module feature_normalize_quantize_tb;

  localparam int          LIMIT_CYCLES = 500_000;
  localparam int          HOLD_CYCLES  = 500;
  localparam int          DRAIN_CYCLES = 40;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam logic [31:0] Q15_ONE      = 32'd32768;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [0:0]  cfg_addr  = fnq_pkg::CFG_NUM_LEVELS;
  logic [8:0]  cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  kind      = fnq_pkg::OP_FEATURE;
  logic [7:0]  index     = '0;
  logic [31:0] value     = '0;
  logic [31:0] scale     = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  level;
  logic [5:0]  dim_index;
  logic [9:0]  frame_index;
  logic        last_in_frame;

  int fail_count;
  int pending;
  int results_checked;
  int frame_wraps;
  int hold_req   = 0;
  int burst_left = 0;
  bit gappy      = 1'b1;
  int n_sent     = 0;
  int n_feat     = 0;
  int cycle_cnt  = 0;

  // boundaries as last loaded, used to aim features at and near them
  logic signed [31:0] bound_s [255];

  always #5 clk = ~clk;

  feature_normalize_quantize uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .index_i        (index),
    .value_i        (value),
    .scale_i        (scale),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .level_o        (level),
    .dim_index_o    (dim_index),
    .frame_index_o  (frame_index),
    .last_in_frame_o(last_in_frame)
  );

  feature_normalize_quantize_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_addr_i       (cfg_addr),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .kind_i           (kind),
    .index_i          (index),
    .value_i          (value),
    .scale_i          (scale),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .level_i          (level),
    .dim_index_i      (dim_index),
    .frame_index_i    (frame_index),
    .last_in_frame_i  (last_in_frame),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .results_checked_o(results_checked),
    .frame_wraps_o    (frame_wraps)
  );

  task automatic send_item(input logic [1:0] k, input logic [7:0] ix,
                           input logic [31:0] v, input logic [31:0] s);
    if (burst_left == 0) begin
      if (gappy) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = gappy ? $urandom_range(1, 30) : 1000;
    end
    in_valid <= 1'b1;
    kind     <= k;
    index    <= ix;
    value    <= v;
    scale    <= s;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    n_sent++;
    if (k == fnq_pkg::OP_FEATURE) n_feat++;
  endtask

  task automatic set_config(input logic [8:0] lv, input logic [6:0] dm);
    cfg_we    <= 1'b1;
    cfg_addr  <= fnq_pkg::CFG_NUM_LEVELS;
    cfg_wdata <= lv;
    @(posedge clk);
    cfg_addr  <= fnq_pkg::CFG_FEATURE_DIM;
    cfg_wdata <= 9'(dm);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // loads give no result, so allow for one still in flight after the last result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // load_mode 0: features and unused kinds only, 1: loads that keep the boundaries ascending, 2: any loads
  task automatic run_phase(input logic [8:0] lv, input logic [6:0] dm, input int n_items,
                           input bit gaps, input int load_mode, input bit long_hold);
    int          r;
    logic [7:0]  ix;
    logic [31:0] v;
    logic [31:0] s;
    settle();
    set_config(lv, dm);
    gappy      = gaps;
    burst_left = 0;
    if (long_hold) hold_req <= hold_req + 1;
    for (int i = 0; i < n_items; i++) begin
      r  = $urandom_range(0, 99);
      ix = 8'($urandom_range(0, 255));
      v  = $urandom;
      s  = $urandom;
      if (r < 4) begin
        send_item(KIND_UNUSED, ix, v, s);
      end else if (load_mode > 0 && r < 10) begin
        if ($urandom_range(0, 1)) begin
          v = $urandom_range(0, 200_000) - 100_000;
          s = Q15_ONE + $urandom_range(0, 2000) - 1000;
        end
        send_item(fnq_pkg::OP_LOAD_NORM, ix, v, s);
      end else if (load_mode > 0 && r < 14) begin
        if (ix < 255) begin
          if (load_mode == 1 || $urandom_range(0, 2) != 0)
            v = bound_s[ix] + $urandom_range(0, 2000) - 1000;
          bound_s[ix] = v;
        end
        send_item(fnq_pkg::OP_LOAD_BND, ix, v, s);
      end else begin
        if (r >= 60) v = bound_s[$urandom_range(0, 254)] + $urandom_range(0, 2) - 1;
        send_item(fnq_pkg::OP_FEATURE, ix, v, s);
      end
    end
  endtask

  // receiver: randomly chosen stall patterns, plus long hold-offs on request
  initial begin : receiver
    int served;
    int cnt;
    int mode;
    served = 0;
    cnt    = 0;
    mode   = 0;
    forever begin
      @(posedge clk);
      if (hold_req != served) begin
        served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (cnt % 50 == 0) mode = $urandom_range(0, 3);
        cnt++;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((cnt % 2) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    for (int b = 0; b < 255; b++) begin
      bound_s[b] = (b - 127) * 16_000_000 + $urandom_range(0, 999_999);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity normalization everywhere and an ascending boundary table
    set_config(9'd256, 7'd5);
    for (int d = 0; d < 64; d++) send_item(fnq_pkg::OP_LOAD_NORM, 8'(d), '0, Q15_ONE);
    for (int b = 0; b < 255; b++) send_item(fnq_pkg::OP_LOAD_BND, 8'(b), bound_s[b], $urandom);

    // ends of the value range, exact boundary hits and neighbours
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), 32'h8000_0000, $urandom);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[0], $urandom);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[254], $urandom);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[254] + 1, $urandom);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), 32'h7fff_ffff, $urandom);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[100] - 1, $urandom);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[37], $urandom);
    // unused kind and out-of-range loads must leave the tables alone
    send_item(KIND_UNUSED, 8'd0, $urandom, $urandom);
    send_item(fnq_pkg::OP_LOAD_NORM, 8'd64, $urandom, $urandom);
    send_item(fnq_pkg::OP_LOAD_NORM, 8'd255, $urandom, $urandom);
    send_item(fnq_pkg::OP_LOAD_BND, 8'd255, $urandom, $urandom);

    // dimension lowered to the running count mid-frame
    settle();
    set_config(9'd256, 7'd2);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[200], $urandom);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[0] - 1, $urandom);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), $urandom, $urandom);

    // too few levels, and a zero dimension
    settle();
    set_config(9'd1, 7'd0);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), 32'h7fff_ffff, $urandom);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[3], $urandom);
    settle();
    set_config(9'd0, 7'd1);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[254] + 1, $urandom);

    // single boundary
    settle();
    set_config(9'd2, 7'd1);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[0] - 1, $urandom);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[0], $urandom);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[0] + 1, $urandom);

    // levels and dimension above their maxima saturate
    settle();
    set_config(9'd511, 7'd127);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), 32'h7fff_ffff, $urandom);
    send_item(fnq_pkg::OP_FEATURE, 8'($urandom), bound_s[128], $urandom);

    run_phase(9'd256, 7'd1, 520, 1'b1, 0, 1'b0);
    run_phase(9'd2, 7'd64, 140, 1'b0, 1, 1'b0);
    run_phase(9'd511, 7'd127, 120, 1'b1, 1, 1'b1);
    run_phase(9'd300, 7'd0, 300, 1'b0, 1, 1'b0);
    run_phase(9'd3, 7'd3, 90, 1'b1, 2, 1'b0);
    run_phase(9'($urandom_range(2, 256)), 7'd1, 330, 1'b1, 2, 1'b0);
    settle();

    $display("covered %0d transactions, %0d of them feature elements, %0d results checked",
             n_sent, n_feat, results_checked);
    $display("%0d frame wraps, saturated levels and dimension, %0d-cycle hold, %0d cycles",
             frame_wraps, HOLD_CYCLES, cycle_cnt);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
